/* rtl/core/rgb2yuv_pkg.sv */
// Shared types, constants and helpers for the RGB to YCbCr 4:2:0 converter.
package rgb2yuv_pkg;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 1;
  // Accumulator: signed, 16 fractional bits, holds 255 * 2^16 plus offset
  localparam int ACC_W   = 26;
  localparam int FRAC_W  = 16;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Dimension values after reset
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

  // BT.601-like coefficients, Q0.16
  localparam logic signed [ACC_W-1:0] COEF_YR = 26'sd19595;
  localparam logic signed [ACC_W-1:0] COEF_YG = 26'sd38470;
  localparam logic signed [ACC_W-1:0] COEF_YB = 26'sd7471;
  localparam logic signed [ACC_W-1:0] COEF_UR = -26'sd11076;
  localparam logic signed [ACC_W-1:0] COEF_UG = -26'sd21758;
  localparam logic signed [ACC_W-1:0] COEF_UB = 26'sd32768;
  localparam logic signed [ACC_W-1:0] COEF_VR = 26'sd32768;
  localparam logic signed [ACC_W-1:0] COEF_VG = -26'sd27460;
  localparam logic signed [ACC_W-1:0] COEF_VB = -26'sd5308;
  localparam logic signed [ACC_W-1:0] CHROMA_OFFSET = 26'sd8388608;

  // One input pixel
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  // Position flags travelling with a pixel
  typedef struct packed {
    logic chroma_valid;
    logic frame_last;
  } pos_flags_t;

  // Negative gives 0, integer part above 255 gives 255, fraction dropped
  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (|acc[ACC_W-2:FRAC_W+PIX_W]) begin
      res = '1;
    end else begin
      res = acc[FRAC_W+PIX_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage

/* rtl/core/rgb2yuv_pos_counter.sv */
// Dimension registers and column/row counters that flag chroma sites and frame end.
module rgb2yuv_pos_counter #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rgb2yuv_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]   cfg_data,
  input  logic                            advance,
  output rgb2yuv_pkg::pos_flags_t         flags
);
  import rgb2yuv_pkg::*;

  localparam int CW    = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DIM_W = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIMENSION);

  // Last index of a line or frame, with the dimension clamped to 2..MAX
  function automatic logic [CW-1:0] dim_limit(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] ext;
    logic [DIM_W-1:0] lim;
    ext = DIM_W'(v);
    if (ext < DIM_W'(2)) begin
      lim = DIM_W'(1);
    end else if (ext > MAX_D) begin
      lim = MAX_D - DIM_W'(1);
    end else begin
      lim = ext - DIM_W'(1);
    end
    return lim[CW-1:0];
  endfunction

  logic [CW-1:0] col_limit;
  logic [CW-1:0] row_limit;
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic          line_end;
  logic          last_row;

  // Limits are derived at reset and at the register write
  always_ff @(posedge clk) begin
    if (rst) begin
      col_limit <= dim_limit(RESET_WIDTH);
      row_limit <= dim_limit(RESET_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  col_limit <= dim_limit(cfg_data);
        REG_FRAME_HEIGHT: row_limit <= dim_limit(cfg_data);
        default: ;
      endcase
    end
  end

  assign line_end = column_count >= col_limit;
  assign last_row = row_count >= row_limit;

  // Raster position of the next word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      if (line_end) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  assign flags.chroma_valid = ~(column_count[0] | row_count[0]);
  assign flags.frame_last   = line_end & last_row;

  // Wrap at line end
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    advance && line_end |=> column_count == '0)
    else $error("column did not wrap at line end");

  // Step inside a line
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    advance && !line_end |=> column_count == $past(column_count) + CW'(1) &&
                             row_count == $past(row_count))
    else $error("column did not step");

  // Frame end returns to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    advance && flags.frame_last |=> column_count == '0 && row_count == '0)
    else $error("frame end did not return to origin");

endmodule

/* rtl/core/rgb2yuv_color_math.sv */
// Fixed-point RGB to YCbCr matrix with clamping to one byte per component.
module rgb2yuv_color_math (
  input  rgb2yuv_pkg::pixel_t             pix,
  output logic [rgb2yuv_pkg::PIX_W-1:0]   luma,
  output logic [rgb2yuv_pkg::PIX_W-1:0]   chroma_blue,
  output logic [rgb2yuv_pkg::PIX_W-1:0]   chroma_red
);
  import rgb2yuv_pkg::*;

  logic signed [ACC_W-1:0] r;
  logic signed [ACC_W-1:0] g;
  logic signed [ACC_W-1:0] b;
  logic signed [ACC_W-1:0] y_acc;
  logic signed [ACC_W-1:0] u_acc;
  logic signed [ACC_W-1:0] v_acc;

  // Zero-extend components into the accumulator width
  assign r = $signed({{(ACC_W-PIX_W){1'b0}}, pix.red});
  assign g = $signed({{(ACC_W-PIX_W){1'b0}}, pix.green});
  assign b = $signed({{(ACC_W-PIX_W){1'b0}}, pix.blue});

  // Constant-coefficient products, summed in Q.16
  assign y_acc = COEF_YR * r + COEF_YG * g + COEF_YB * b;
  assign u_acc = COEF_UR * r + COEF_UG * g + COEF_UB * b + CHROMA_OFFSET;
  assign v_acc = COEF_VR * r + COEF_VG * g + COEF_VB * b + CHROMA_OFFSET;

  assign luma        = clamp_byte(y_acc);
  assign chroma_blue = clamp_byte(u_acc);
  assign chroma_red  = clamp_byte(v_acc);

endmodule

/* rtl/core/rgb_to_yuv420_converter.sv */
// Top level: RGB pixel stream in, YCbCr 4:2:0-tagged pixel stream out.
//
// Input channel s_axis_*: one BGR pixel per word, raster order.
// Output channel m_axis_*: one word per input pixel with Y, Cb, Cr of that
// pixel; tuser marks the pixels that carry the 4:2:0 chroma sample (even row
// and even column), tlast marks the last pixel of the frame.
// Configuration: cfg_we writes cfg_data to register cfg_index (0: frame width,
// 1: frame height), taken at once; write only while the stream is idle.
// Dimensions are clamped to 2..MAX_DIMENSION.
// Stages: input register, then result register, with the color matrix
// between them.
// Throughput: one pixel per clock; both stages advance together whenever the
// output register is empty or being taken.
// Reset: rst is synchronous; it empties both stages, sets 640 x 480 and puts
// the raster position at row 0, column 0.
// Stall: with m_axis_tready low the output word holds, the input register
// still fills once, and s_axis_tready drops only when both stages are full.
module rgb_to_yuv420_converter #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [rgb2yuv_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]   cfg_data,
  // Pixel input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // blue, green, red
  // Pixel output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // luma, chroma_blue, chroma_red
  output logic                            m_axis_tuser,  // chroma_valid
  output logic                            m_axis_tlast   // frame_last
);
  import rgb2yuv_pkg::*;

  logic       advance;
  logic       accept;
  pos_flags_t pos_flags;

  logic       s1_valid;
  pixel_t     s1_pix;
  pos_flags_t s1_flags;

  logic [PIX_W-1:0] y_val;
  logic [PIX_W-1:0] cb_val;
  logic [PIX_W-1:0] cr_val;

  // Pipeline moves when the output register is free or being drained
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rgb2yuv_pos_counter #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .flags     (pos_flags)
  );

  // Input register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix.blue  <= s_axis_tdata[7:0];
      s1_pix.green <= s_axis_tdata[15:8];
      s1_pix.red   <= s_axis_tdata[23:16];
      s1_flags     <= pos_flags;
    end
  end

  rgb2yuv_color_math u_math (
    .pix         (s1_pix),
    .luma        (y_val),
    .chroma_blue (cb_val),
    .chroma_red  (cr_val)
  );

  // Result register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_axis_tdata <= {cr_val, cb_val, y_val};
      m_axis_tuser <= s1_flags.chroma_valid;
      m_axis_tlast <= s1_flags.frame_last;
    end
  end

  // A full input stage moving forward lands in the output register
  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> m_axis_tvalid)
    else $error("word lost between stages");

  // Input is refused only when both stages hold a word
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input refused with room in pipeline");

  // A held input word stays in place while the output is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_pix) && $stable(s1_flags))
    else $error("input stage changed under stall");

endmodule
